>>> design/lmx_pkg.sv
// Package for the Lamport mutual exclusion node: shared constants, codes and types.
// Used by lmx_ctrl, lmx_datapath and lamport_mutex_node; depends on nothing.
package lmx_pkg;

  // Default sizes for the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int ID_W    = 4;
  localparam int MTIME_W = 16;
  localparam int QCNT_W  = 5;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_LOCAL_REQ = 2'd0;
  localparam logic [1:0] OP_LOCAL_REL = 2'd1;
  localparam logic [1:0] OP_RECEIVED  = 2'd2;

  // Kinds of a received message.
  localparam logic [1:0] MSG_REQUEST = 2'd0;
  localparam logic [1:0] MSG_REPLY   = 2'd1;
  localparam logic [1:0] MSG_RELEASE = 2'd2;
  localparam logic [1:0] MSG_DONE    = 2'd3;

  // Kinds of an outgoing message.
  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_REPLY   = 2'd2;
  localparam logic [1:0] SEND_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROC = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         msg_type;
    logic [ID_W-1:0]    sender_id;
    logic [MTIME_W-1:0] msg_time;
  } lmx_item_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic [MTIME_W-1:0] send_time;
    logic [ID_W-1:0]    dest_id;
    logic               may_enter;
    logic [QCNT_W-1:0]  queue_count;
    logic [CNT_W-1:0]   reply_total;
    logic [CNT_W-1:0]   done_total;
    logic               overflow;
  } lmx_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic ins_shift;
    logic ins_put;
    logic pop_shift;
    logic emit;
  } lmx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins_scan;
    logic ins_direct;
    logic pop_scan;
    logic entry_after;
    logic ptr_one;
    logic pop_last;
  } lmx_stat_t;

endpackage

>>> design/lamport_mutex_node.sv
// Top level of one Lamport mutual exclusion node.
// Depends on lmx_pkg and instantiates lmx_ctrl and lmx_datapath.

// One node of Lamport's distributed mutual exclusion. Each input beat is one event (a local
// request, a local release or a received message); it is taken at a rising edge where start
// is high and busy is low, and it produces exactly one result beat, shown on result_o for a
// single cycle while done_o is high. The receiver cannot hold results off, so it must capture
// the beat in that cycle. An event that neither inserts into nor pops from the request queue
// goes from decode straight to result issue; a pop first moves every entry behind the head
// down one slot, and a sorted insert first moves every entry that sorts after the new one up
// one slot and then writes it. The queue memory has a single write port, so queue entries
// move one slot per cycle while a new entry looks for its place or the head is removed. A new
// beat can be taken in the cycle that carries the previous result. Configuration (own_id at
// index 0, num_processes at index 1) must be written through cfg_we_i only while the node is
// idle; the block itself does not enforce this. Queue entries that were never written are
// never read for any reported value, so the queue memory needs no clearing after reset.
module lamport_mutex_node
  import lmx_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  lmx_item_t             item_i,
  output logic                  done_o,
  output lmx_result_t           result_o
);

  lmx_cmd_t  cmd;
  lmx_stat_t stat;

  // The controller walks each event through decode, queue shifting and result issue.
  lmx_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // The datapath holds the Lamport clock, the counters, the sorted queue and the result.
  lmx_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o)
  );

  // An accepted beat always keeps the node busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("node not busy after accepting a beat");

  // Results are single-cycle strobes and each one closes a busy period.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result issued without a busy period");

  // A beat that sends nothing carries no timestamp, no destination and no overflow flag.
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.send_kind == SEND_NONE)) |->
      ((result_o.send_time == '0) && (result_o.dest_id == '0) && !result_o.overflow))
    else $error("idle send carries stamp, destination or overflow");

endmodule

>>> design/lmx_queue.sv
// Request queue storage: one write port and one read port with registered read data.
// Depends on nothing outside this file.
module lmx_queue #(
  parameter int DEPTH   = 16,
  parameter int ENTRY_W = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ENTRY_W-1:0]       wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ENTRY_W-1:0]       rdata_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lmx_ctrl.sv
// Controller of the Lamport node: sequences decode, queue shifting and result issue.
// Depends on lmx_pkg for the command and status types.
module lmx_ctrl
  import lmx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output lmx_cmd_t  cmd_o,
  input  lmx_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_SCAN,
    S_INS_PUT,
    S_POP_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.ins_scan) begin
          state_d = S_INS_SCAN;
        end else if (stat_i.ins_direct) begin
          state_d = S_INS_PUT;
        end else if (stat_i.pop_scan) begin
          state_d = S_POP_SHIFT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_INS_SCAN: begin
        // An entry that sorts after the new key moves up one slot.
        if (stat_i.entry_after) begin
          cmd_o.ins_shift = 1'b1;
          if (stat_i.ptr_one) begin
            state_d = S_INS_PUT;
          end
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_INS_PUT: begin
        cmd_o.ins_put = 1'b1;
        state_d       = S_FINISH;
      end
      S_POP_SHIFT: begin
        cmd_o.pop_shift = 1'b1;
        if (stat_i.pop_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.emit = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

>>> design/lmx_datapath.sv
// Datapath of the Lamport node: clock, counters, configuration, queue pointer and result.
// Depends on lmx_pkg and instantiates lmx_queue.
module lmx_datapath
  import lmx_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  lmx_item_t             item_i,
  input  lmx_cmd_t              cmd_i,
  output lmx_stat_t             stat_o,
  output lmx_result_t           result_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + ID_W;
  localparam logic [32:0] TimeMaxW = (33'd1 << TIME_BITS) - 33'd1;

  logic [ID_W-1:0]      own_id_q;
  logic [ID_W-1:0]      nproc_q;
  lmx_item_t            item_q;
  logic [TIME_BITS-1:0] clock_q;
  logic [LW-1:0]        len_q;
  logic [CNT_W-1:0]     reply_q;
  logic [CNT_W-1:0]     done_cnt_q;
  logic [EW-1:0]        key_q;
  logic [AW-1:0]        ptr_q;
  logic [ID_W-1:0]      head_id_q;
  lmx_result_t          res_q;

  logic                 is_local_req, is_local_rel, is_rx;
  logic                 rx_req, rx_reply, rx_rel, rx_done;
  logic                 do_insert, do_pop, full, empty;
  logic [TIME_BITS-1:0] mtime_sat, tick_base, tick_val;
  logic                 clock_moves;
  logic [ID_W-1:0]      need;
  logic [1:0]           kind;

  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_wdata, mem_rdata;

  // Decode of the latched beat.
  assign is_local_req = (item_q.opcode == OP_LOCAL_REQ);
  assign is_local_rel = (item_q.opcode == OP_LOCAL_REL);
  assign is_rx        = (item_q.opcode == OP_RECEIVED);
  assign rx_req       = is_rx && (item_q.msg_type == MSG_REQUEST);
  assign rx_reply     = is_rx && (item_q.msg_type == MSG_REPLY);
  assign rx_rel       = is_rx && (item_q.msg_type == MSG_RELEASE);
  assign rx_done      = is_rx && (item_q.msg_type == MSG_DONE);
  assign do_insert    = is_local_req || rx_req;
  assign do_pop       = is_local_rel || rx_rel;
  assign full         = (len_q == LW'(QUEUE_DEPTH));
  assign empty        = (len_q == '0);
  assign clock_moves  = is_local_req || is_local_rel || is_rx;

  // A timestamp beyond the clock range saturates to the clock maximum.
  assign mtime_sat = (33'(item_q.msg_time) > TimeMaxW) ? '1 : TIME_BITS'(item_q.msg_time);
  assign tick_base = (is_rx && (mtime_sat > clock_q)) ? mtime_sat : clock_q;
  assign tick_val  = (&tick_base) ? tick_base : tick_base + TIME_BITS'(1);

  always_comb begin
    if (is_local_req) begin
      kind = SEND_REQUEST;
    end else if (is_local_rel) begin
      kind = SEND_RELEASE;
    end else if (rx_req) begin
      kind = SEND_REPLY;
    end else begin
      kind = SEND_NONE;
    end
  end

  assign need = (nproc_q == '0) ? '0 : nproc_q - ID_W'(1);

  // Queue port control.
  assign mem_we    = cmd_i.ins_shift || cmd_i.ins_put || cmd_i.pop_shift;
  assign mem_wdata = cmd_i.ins_put ? key_q : mem_rdata;

  always_comb begin
    mem_raddr = '0;
    if (cmd_i.exec) begin
      mem_raddr = do_insert ? AW'(len_q - LW'(1)) : AW'(1);
    end else if (cmd_i.ins_shift) begin
      mem_raddr = ptr_q - AW'(2);
    end else if (cmd_i.pop_shift) begin
      mem_raddr = ptr_q + AW'(2);
    end
  end

  lmx_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .ENTRY_W (EW)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Status toward the controller.
  assign stat_o.ins_scan    = do_insert && !full && !empty;
  assign stat_o.ins_direct  = do_insert && !full && empty;
  assign stat_o.pop_scan    = do_pop && (len_q >= LW'(2));
  assign stat_o.entry_after = (mem_rdata > key_q);
  assign stat_o.ptr_one     = (ptr_q == AW'(1));
  assign stat_o.pop_last    = ((LW'(ptr_q) + LW'(1)) == len_q);

  // Configuration and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= ID_W'(1);
      nproc_q    <= ID_W'(2);
      clock_q    <= '0;
      len_q      <= '0;
      reply_q    <= '0;
      done_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OWN_ID:   own_id_q <= cfg_data_i;
          REG_NUM_PROC: nproc_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.exec) begin
        if (clock_moves) begin
          clock_q <= tick_val;
        end
        if (do_insert && !full) begin
          len_q <= len_q + LW'(1);
        end else if (do_pop && !empty) begin
          len_q <= len_q - LW'(1);
        end
        if (is_local_rel) begin
          reply_q <= '0;
        end else if (rx_reply && (reply_q != CNT_MAX)) begin
          reply_q <= reply_q + CNT_W'(1);
        end
        if (rx_done && (done_cnt_q != CNT_MAX)) begin
          done_cnt_q <= done_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      key_q <= is_local_req ? {tick_val, own_id_q} : {mtime_sat, item_q.sender_id};
      ptr_q <= do_insert ? AW'(len_q) : '0;
      res_q.send_kind <= kind;
      res_q.send_time <= (kind == SEND_NONE) ? '0 : MTIME_W'(tick_val);
      res_q.dest_id   <= rx_req ? item_q.sender_id : '0;
      res_q.overflow  <= do_insert && full;
    end else if (cmd_i.ins_shift) begin
      ptr_q <= ptr_q - AW'(1);
    end else if (cmd_i.pop_shift) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (mem_we && (ptr_q == '0)) begin
      head_id_q <= mem_wdata[ID_W-1:0];
    end
    if (cmd_i.emit) begin
      res_q.may_enter   <= !empty && (head_id_q == own_id_q) && (reply_q >= need);
      res_q.queue_count <= QCNT_W'(len_q);
      res_q.reply_total <= reply_q;
      res_q.done_total  <= done_cnt_q;
    end
  end

  assign result_o = res_q;

endmodule

>>> sim/tb_lamport_mutex_node.sv
`timescale 1ns / 100ps
// Self-checking testbench for lamport_mutex_node: directed table, random protocol rounds.
// Depends on lmx_pkg and the node RTL; expected beats come from a predictor kept in here.
module tb_lamport_mutex_node;
  import lmx_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam logic [MTIME_W-1:0] CLOCK_TOP = '1;
  // The package gives no name to the fourth opcode; the node must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Longest quiet stretch: the sender's longest idle gap plus a full-depth shift,
  // taken many times over.
  localparam int IDLE_LIMIT = 400;
  localparam int SETTLE_CYCLES = QDEPTH + 8;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 100;

  // One row of the directed table. Rows with typed set carry a hand-written result;
  // the others are checked against the predictor.
  typedef struct {
    lmx_item_t   stim;
    bit          typed;
    lmx_result_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  lmx_item_t   item_i = '0;
  logic        done_o;
  lmx_result_t result_o;

  // Predictor state: Lamport clock, sorted request queue, counters and the
  // configuration that the node should hold.
  logic [MTIME_W-1:0] node_clock = '0;
  logic [MTIME_W-1:0] pend_time [QDEPTH];
  logic [ID_W-1:0]    pend_id   [QDEPTH];
  int                 pend_len = 0;
  logic [CNT_W-1:0]   reply_cnt = '0;
  logic [CNT_W-1:0]   done_cnt = '0;
  logic [ID_W-1:0]    cfg_own = 4'd1;
  logic [ID_W-1:0]    cfg_nproc = 4'd2;

  lmx_result_t due_results [$];
  row_t        script [$];
  int          err_cnt = 0;
  int          beat_total = 0;
  int          idle_cycles = 0;
  bit          eager_sender = 1'b0;

  lamport_mutex_node u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The clock saturates rather than wraps.
  function automatic logic [MTIME_W-1:0] clock_tick(input logic [MTIME_W-1:0] t);
    return (t == CLOCK_TOP) ? t : t + MTIME_W'(1);
  endfunction

  // Sorted insert by (time, id). A new entry goes behind equal keys. Returns 1 when
  // the queue is full and the entry is dropped.
  function automatic logic queue_put(input logic [MTIME_W-1:0] t, input logic [ID_W-1:0] id);
    int pos;
    int k;
    if (pend_len >= QDEPTH) return 1'b1;
    pos = pend_len;
    while (pos > 0 && (pend_time[pos-1] > t || (pend_time[pos-1] == t && pend_id[pos-1] > id)))
      pos--;
    for (k = pend_len; k > pos; k--) begin
      pend_time[k] = pend_time[k-1];
      pend_id[k]   = pend_id[k-1];
    end
    pend_time[pos] = t;
    pend_id[pos]   = id;
    pend_len++;
    return 1'b0;
  endfunction

  // Removing the head of an empty queue leaves it alone.
  function automatic void queue_drop_head();
    int k;
    if (pend_len == 0) return;
    for (k = 0; k + 1 < pend_len; k++) begin
      pend_time[k] = pend_time[k+1];
      pend_id[k]   = pend_id[k+1];
    end
    pend_len--;
  endfunction

  // Applies one event to the predictor state and returns the beat the node should send.
  function automatic lmx_result_t predict_event(input lmx_item_t it);
    lmx_result_t        r;
    logic [MTIME_W-1:0] seen;
    logic [CNT_W-1:0]   need;
    r = '0;
    case (it.opcode)
      OP_LOCAL_REQ: begin
        node_clock  = clock_tick(node_clock);
        r.overflow  = queue_put(node_clock, cfg_own);
        r.send_kind = SEND_REQUEST;
        r.send_time = node_clock;
      end
      OP_LOCAL_REL: begin
        queue_drop_head();
        reply_cnt   = '0;
        node_clock  = clock_tick(node_clock);
        r.send_kind = SEND_RELEASE;
        r.send_time = node_clock;
      end
      OP_RECEIVED: begin
        // Receive rule: max(local, message) + 1.
        seen = (it.msg_time > node_clock) ? it.msg_time : node_clock;
        node_clock = clock_tick(seen);
        case (it.msg_type)
          MSG_REQUEST: begin
            r.overflow  = queue_put(it.msg_time, it.sender_id);
            r.send_kind = SEND_REPLY;
            r.send_time = node_clock;
            r.dest_id   = it.sender_id;
          end
          MSG_REPLY:   if (reply_cnt != CNT_MAX) reply_cnt++;
          MSG_RELEASE: queue_drop_head();
          MSG_DONE:    if (done_cnt != CNT_MAX) done_cnt++;
        endcase
      end
      OP_UNUSED: ;
    endcase
    // With zero processes configured no replies are needed.
    need = (cfg_nproc == '0) ? '0 : cfg_nproc - ID_W'(1);
    r.may_enter   = (pend_len > 0) && (pend_id[0] == cfg_own) && (reply_cnt >= need);
    r.queue_count = QCNT_W'(pend_len);
    r.reply_total = reply_cnt;
    r.done_total  = done_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic lmx_item_t make_item(input logic [1:0] op, input logic [1:0] mt,
                                          input logic [ID_W-1:0] id,
                                          input logic [MTIME_W-1:0] t);
    lmx_item_t it;
    it.opcode    = op;
    it.msg_type  = mt;
    it.sender_id = id;
    it.msg_time  = t;
    return it;
  endfunction

  // Timestamps mostly sit around the node's own clock so that the clock keeps moving
  // without saturating; some repeat a queued key to exercise equal-key ordering.
  function automatic logic [MTIME_W-1:0] near_time();
    case ($urandom_range(0, 4))
      0: return MTIME_W'($urandom_range(0, node_clock));
      1: return node_clock;
      2: return node_clock + MTIME_W'($urandom_range(1, 6));
      3: return (pend_len > 0) ? pend_time[$urandom_range(0, pend_len - 1)] : '0;
      default: return MTIME_W'($urandom_range(0, 3));
    endcase
  endfunction

  // A received message from a random peer; repeats a queued sender now and then.
  function automatic lmx_item_t rx_item(input logic [1:0] mt);
    logic [ID_W-1:0] id;
    id = (pend_len > 0 && $urandom_range(0, 3) == 0) ? pend_id[$urandom_range(0, pend_len - 1)]
                                                    : ID_W'($urandom_range(0, 15));
    return make_item(OP_RECEIVED, mt, id, near_time());
  endfunction

  // Local events ignore the message fields, so those carry random content.
  function automatic lmx_item_t local_item(input logic [1:0] op);
    return make_item(op, 2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                     MTIME_W'($urandom));
  endfunction

  // Offers one beat after a random idle gap and waits for the node to take it.
  // start stays high across back-to-back beats so it never sees two updates in
  // one time step.
  task automatic send_beat(input lmx_item_t it, input bit typed, input lmx_result_t want);
    int          gap;
    lmx_result_t guess;
    gap = eager_sender ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    guess = predict_event(it);
    due_results.push_back(typed ? want : guess);
  endtask

  task automatic post_event(input lmx_item_t it);
    send_beat(it, 1'b0, '0);
    if (it.opcode != OP_UNUSED) beat_total++;
  endtask

  // Lowers start and waits until every expected beat has come back.
  task automatic drain_results();
    if (start) start <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // Both registers are written on consecutive edges; only done while idle.
  task automatic write_config(input logic [ID_W-1:0] own, input logic [ID_W-1:0] nproc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_OWN_ID;
    cfg_data_i <= own;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NUM_PROC;
    cfg_data_i <= nproc;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_own   = own;
    cfg_nproc = nproc;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_beat(input lmx_result_t got, input lmx_result_t want);
    if (got.send_kind   !== want.send_kind)   report("send_kind", got.send_kind, want.send_kind);
    if (got.send_time   !== want.send_time)   report("send_time", got.send_time, want.send_time);
    if (got.dest_id     !== want.dest_id)     report("dest_id", got.dest_id, want.dest_id);
    if (got.may_enter   !== want.may_enter)   report("may_enter", got.may_enter, want.may_enter);
    if (got.queue_count !== want.queue_count)
      report("queue_count", got.queue_count, want.queue_count);
    if (got.reply_total !== want.reply_total)
      report("reply_total", got.reply_total, want.reply_total);
    if (got.done_total  !== want.done_total)
      report("done_total", got.done_total, want.done_total);
    if (got.overflow    !== want.overflow)    report("overflow", got.overflow, want.overflow);
  endtask

  // A result beat lives for one cycle only, so it is taken at every edge where done_o
  // is high and compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) report("result beat with nothing expected", result_o, '0);
      else check_beat(result_o, due_results.pop_front());
    end
  end

  // Watchdog: ends the run when neither side has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lamport_mutex_node: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int              k;
    int              n;
    int              n_open;
    int              phase;
    int              pick;
    logic [ID_W-1:0] own;
    logic [ID_W-1:0] nproc;

    // Directed table, run with the reset configuration (own id 1, two processes).
    // The first rows start from a fresh node, so their results are typed in.
    // An unused opcode with every field at its top changes nothing.
    script.push_back('{make_item(OP_UNUSED, MSG_DONE, 4'hF, 16'hFFFF), 1'b1, '0});
    // Done message: the clock goes to 1 and the done count to 1.
    script.push_back('{make_item(OP_RECEIVED, MSG_DONE, 4'd0, 16'd0), 1'b1,
                       lmx_result_t'{SEND_NONE, 16'd0, 4'd0, 1'b0, 5'd0, 4'd0, 4'd1, 1'b0}});
    // Reply: clock 2, one reply counted.
    script.push_back('{make_item(OP_RECEIVED, MSG_REPLY, 4'hF, 16'd0), 1'b1,
                       lmx_result_t'{SEND_NONE, 16'd0, 4'd0, 1'b0, 5'd0, 4'd1, 4'd1, 1'b0}});
    // Local release of an empty queue: clock 3, replies cleared, queue untouched.
    script.push_back('{make_item(OP_LOCAL_REL, MSG_REQUEST, 4'd0, 16'd0), 1'b1,
                       lmx_result_t'{SEND_RELEASE, 16'd3, 4'd0, 1'b0, 5'd0, 4'd0, 4'd1, 1'b0}});
    // Remote release of an empty queue.
    script.push_back('{make_item(OP_RECEIVED, MSG_RELEASE, 4'd6, 16'd0), 1'b0, '0});
    // Own request lands at time 5; peers then queue around it, including a key equal
    // to our own, a same-time lower id, and an older stamp that takes the head.
    script.push_back('{make_item(OP_LOCAL_REQ, MSG_REQUEST, 4'd0, 16'd0), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REQUEST, 4'd2, 16'd5), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REQUEST, 4'd0, 16'd5), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REQUEST, 4'd1, 16'd5), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REQUEST, 4'd3, 16'd0), 1'b0, '0});
    // Enough replies, but the head is someone else until two releases arrive.
    script.push_back('{make_item(OP_RECEIVED, MSG_REPLY, 4'd2, 16'd40), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_RELEASE, 4'd3, 16'd1), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_RELEASE, 4'd0, 16'd2), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_DONE, 4'd7, 16'd0), 1'b0, '0});
    script.push_back('{make_item(OP_LOCAL_REL, MSG_DONE, 4'hF, 16'hFFFF), 1'b0, '0});
    script.push_back('{make_item(OP_UNUSED, MSG_REQUEST, 4'd0, 16'd0), 1'b0, '0});
    script.push_back('{make_item(OP_LOCAL_REQ, MSG_DONE, 4'hF, 16'hFFFF), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REPLY, 4'd9, 16'd0), 1'b0, '0});
    script.push_back('{make_item(OP_LOCAL_REL, MSG_REQUEST, 4'd0, 16'd0), 1'b0, '0});
    n_open = script.size();
    // Closing rows: a stamp at the top of the range drives the clock into saturation.
    // They run last because a saturated clock never comes down again.
    script.push_back('{make_item(OP_RECEIVED, MSG_REPLY, 4'hF, 16'hFFFF), 1'b0, '0});
    script.push_back('{make_item(OP_LOCAL_REQ, MSG_REQUEST, 4'd0, 16'd0), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_REQUEST, 4'hF, 16'hFFFF), 1'b0, '0});
    script.push_back('{make_item(OP_RECEIVED, MSG_DONE, 4'hF, 16'hFFFF), 1'b0, '0});
    script.push_back('{make_item(OP_LOCAL_REL, MSG_RELEASE, 4'd0, 16'd0), 1'b0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < n_open; k++) send_beat(script[k].stim, script[k].typed, script[k].want);

    // Random part. Each phase runs under its own configuration, covering the
    // extremes of both registers; one phase draws both at random.
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin own = 4'd2;  nproc = 4'd3;  end
        1: begin own = 4'd15; nproc = 4'd15; end
        2: begin own = 4'd1;  nproc = 4'd1;  end
        3: begin own = 4'd9;  nproc = 4'd0;  end
        4: begin
          own   = ID_W'($urandom_range(0, 15));
          nproc = ID_W'($urandom_range(0, 15));
        end
        default: begin own = 4'd3; nproc = 4'd4; end
      endcase
      write_config(own, nproc);
      n = beat_total + BEATS_PER_PHASE;
      while (beat_total < n) begin
        // Runs of back-to-back beats alternate with randomly spaced ones.
        eager_sender = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // A critical-section round as the protocol expects it: request, replies
          // (a few extra to reach saturation), other peers' requests mixed in,
          // release, then releases from others.
          post_event(local_item(OP_LOCAL_REQ));
          for (k = 0; k + 1 < cfg_nproc + $urandom_range(0, 2); k++) begin
            if ($urandom_range(0, 3) == 0) post_event(rx_item(MSG_REQUEST));
            post_event(rx_item(MSG_REPLY));
          end
          if ($urandom_range(0, 5) == 0) post_event(rx_item(MSG_DONE));
          post_event(local_item(OP_LOCAL_REL));
          repeat ($urandom_range(0, 2)) post_event(rx_item(MSG_RELEASE));
        end else if (pick < 65) begin
          // Flood of peer requests, enough to overfill the queue.
          repeat (QDEPTH + 2) post_event(rx_item(MSG_REQUEST));
        end else if (pick < 70) begin
          // Releases with no matching request, running the queue dry.
          repeat (QDEPTH + 2) post_event(rx_item(MSG_RELEASE));
        end else begin
          post_event(make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               ID_W'($urandom_range(0, 15)), near_time()));
        end
      end
    end

    for (k = n_open; k < script.size(); k++)
      send_beat(script[k].stim, script[k].typed, script[k].want);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_lamport_mutex_node: clean");
    end else begin
      $display("tb_lamport_mutex_node: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lmx_pkg.sv
design/lmx_queue.sv
design/lmx_ctrl.sv
design/lmx_datapath.sv
design/lamport_mutex_node.sv
sim/tb_lamport_mutex_node.sv
